@@ hdl/servo_output_scale_failsafe_assert.svh @@
// ----------------------------------------------------------------------------
// servo output scale assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef SERVO_OUTPUT_SCALE_FAILSAFE_ASSERT_SVH
`define SERVO_OUTPUT_SCALE_FAILSAFE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SOSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SOSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SOSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SOSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hdl/sosf_pkg.sv @@
// ----------------------------------------------------------------------------
// sosf_pkg
// shared widths, calibration layout and controller/datapath interface types
// ----------------------------------------------------------------------------
package sosf_pkg;

    localparam int VAL_W     = 12;
    localparam int SLOT_W    = 3;
    localparam int CAL_W     = 50;
    localparam int CAL_REGS  = 8;
    localparam int CAL_IDX_W = 3;

    localparam logic [CAL_W-1:0] CAL_RESET = 50'd412350420993000;

    // calibration word layout
    localparam int LO_LSB   = 0;
    localparam int MID_LSB  = 12;
    localparam int HI_LSB   = 24;
    localparam int REV_BIT  = 36;
    localparam int FIX_BIT  = 37;
    localparam int FIXV_LSB = 38;

    // product magnitude, quotient and scaled sum widths
    localparam int PROD_W = 2 * VAL_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    typedef struct packed {
        logic capture;
        logic prep;
        logic mul;
        logic div_step;
        logic sum;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic direct;
    } t_status;

endpackage

@@ hdl/sosf_in_if.sv @@
// ----------------------------------------------------------------------------
// sosf_in_if
// input channel: slot index, validity flag and raw channel value
// ----------------------------------------------------------------------------
interface sosf_in_if;

    logic                            valid;
    logic                            ready;
    logic [sosf_pkg::SLOT_W-1:0]     slot_index;
    logic                            source_valid;
    logic [sosf_pkg::VAL_W-1:0]      raw_value;

    modport source (output valid, slot_index, source_valid, raw_value, input ready);
    modport sink   (input valid, slot_index, source_valid, raw_value, output ready);

endinterface

@@ hdl/sosf_out_if.sv @@
// ----------------------------------------------------------------------------
// sosf_out_if
// output channel: slot echo and saturated servo pulse value
// ----------------------------------------------------------------------------
interface sosf_out_if;

    logic                            valid;
    logic                            ready;
    logic [sosf_pkg::SLOT_W-1:0]     slot_echo;
    logic [sosf_pkg::VAL_W-1:0]      servo_value;

    modport source (output valid, slot_echo, servo_value, input ready);
    modport sink   (input valid, slot_echo, servo_value, output ready);

endinterface

@@ hdl/sosf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// sosf_cfg_regs
// per-slot calibration register file, written by index, read by slot
// ----------------------------------------------------------------------------
module sosf_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_we,
    input  logic [sosf_pkg::CAL_IDX_W-1:0]  i_index,
    input  logic [sosf_pkg::CAL_W-1:0]      i_data,
    input  logic [sosf_pkg::SLOT_W-1:0]     i_rd_slot,
    output logic [sosf_pkg::CAL_W-1:0]      o_cal
);

    logic [sosf_pkg::CAL_W-1:0] r_cal [sosf_pkg::CAL_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sosf_pkg::CAL_REGS; i++) begin
                r_cal[i] <= sosf_pkg::CAL_RESET;
            end
        end else if (i_we) begin
            r_cal[i_index] <= i_data;
        end
    end

    assign o_cal = r_cal[i_rd_slot];

endmodule

@@ hdl/sosf_ctrl.sv @@
// ----------------------------------------------------------------------------
// sosf_ctrl
// sequencing fsm: capture, prepare, multiply, divide, sum, output load
// ----------------------------------------------------------------------------
module sosf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sosf_pkg::t_cmd    o_cmd,
    input  sosf_pkg::t_status i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV,
        S_SUM,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                // failsafe, ignored slot and zero-width source span skip the multiply and divider
                n_state    = i_status.direct ? S_SUM : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ hdl/sosf_datapath.sv @@
// ----------------------------------------------------------------------------
// sosf_datapath
// segment mapping with reciprocal-multiply divider, reverse, saturation, hold
// ----------------------------------------------------------------------------
module sosf_datapath #(
    parameter int SLOT_COUNT    = 8,
    parameter int SOURCE_MIN    = 1000,
    parameter int SOURCE_CENTER = 1500,
    parameter int SOURCE_MAX    = 2000
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sosf_pkg::t_cmd                 i_cmd,
    output sosf_pkg::t_status              o_status,
    input  logic [sosf_pkg::SLOT_W-1:0]    i_slot_index,
    input  logic                           i_source_valid,
    input  logic [sosf_pkg::VAL_W-1:0]     i_raw_value,
    input  logic [sosf_pkg::CAL_W-1:0]     i_cal,
    output logic [sosf_pkg::SLOT_W-1:0]    o_cal_slot,
    output logic [sosf_pkg::SLOT_W-1:0]    o_slot_echo,
    output logic [sosf_pkg::VAL_W-1:0]     o_servo_value
);

    localparam int VW = sosf_pkg::VAL_W;
    localparam int PW = sosf_pkg::PROD_W;
    localparam int SW = sosf_pkg::SUM_W;
    localparam int RW = PW + 2;
    localparam int HOLD_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [VW-1:0] SRC_MIN_V    = VW'(SOURCE_MIN);
    localparam logic [VW-1:0] SRC_CENTER_V = VW'(SOURCE_CENTER);

    localparam int SPAN_LO = SOURCE_CENTER - SOURCE_MIN;
    localparam int SPAN_HI = SOURCE_MAX - SOURCE_CENTER;
    localparam int SPAN_LO_ABS = (SPAN_LO < 0) ? -SPAN_LO : SPAN_LO;
    localparam int SPAN_HI_ABS = (SPAN_HI < 0) ? -SPAN_HI : SPAN_HI;
    localparam logic [VW-1:0] SPAN_LO_MAG = VW'(SPAN_LO_ABS);
    localparam logic [VW-1:0] SPAN_HI_MAG = VW'(SPAN_HI_ABS);
    localparam logic          SPAN_LO_NEG = (SPAN_LO < 0);
    localparam logic          SPAN_HI_NEG = (SPAN_HI < 0);

    // reciprocal of each span: ceil(2^(PW+l)/d), l = clog2(d), exact for PW-bit dividends
    localparam int SPAN_LO_D = (SPAN_LO_ABS == 0) ? 1 : SPAN_LO_ABS;
    localparam int SPAN_HI_D = (SPAN_HI_ABS == 0) ? 1 : SPAN_HI_ABS;
    localparam int SHIFT_LO  = PW + $clog2(SPAN_LO_D);
    localparam int SHIFT_HI  = PW + $clog2(SPAN_HI_D);
    localparam longint REC_LO = ((longint'(1) << SHIFT_LO) + longint'(SPAN_LO_D) - 1)
                                / longint'(SPAN_LO_D);
    localparam longint REC_HI = ((longint'(1) << SHIFT_HI) + longint'(SPAN_HI_D) - 1)
                                / longint'(SPAN_HI_D);
    localparam logic [RW-1:0] REC_LO_V = RW'(REC_LO);
    localparam logic [RW-1:0] REC_HI_V = RW'(REC_HI);

    localparam logic [sosf_pkg::SLOT_W:0] SLOT_LIMIT = (sosf_pkg::SLOT_W + 1)'(SLOT_COUNT);

    // captured transaction
    logic [sosf_pkg::SLOT_W-1:0] r_slot;
    logic                        r_valid;
    logic [VW-1:0]               r_raw;

    // prepared operands
    logic [VW-1:0] r_lo, r_mid, r_hi, r_fixv;
    logic          r_rev, r_fix;
    logic [VW-1:0] r_dx_mag, r_dy_mag, r_base, r_endpt;
    logic [RW-1:0] r_recip;
    logic          r_neg, r_span_zero, r_scaled, r_upper;

    // product and quotient
    logic [PW-1:0] r_prod;
    logic [PW-1:0] r_quo;

    // summed result
    logic [SW-1:0] r_v;
    logic [VW-1:0] r_direct;

    // hold store
    logic [VW-1:0]         r_hold_val [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_hold_known;

    // output register
    logic [sosf_pkg::SLOT_W-1:0] r_out_slot;
    logic [VW-1:0]               r_out_val;

    logic                  w_slot_ok, w_upper, w_span_neg, w_span_zero;
    logic [VW-1:0]         w_span_mag, w_lo, w_mid, w_hi, w_src_a, w_out_a, w_out_b;
    logic [VW:0]           w_dx, w_dy, w_dx_abs, w_dy_abs;
    logic [PW-1:0]         w_prod;
    logic [PW+RW-1:0]      w_qprod;
    logic [PW-1:0]         w_quo;
    logic [SW-1:0]         w_q_ext, w_sq, w_sum;
    logic [HOLD_IDX_W-1:0] w_hidx;
    logic [VW-1:0]         w_hold;
    logic                  w_known;
    logic [SW:0]           w_rev_v, w_fin;
    logic [VW-1:0]         w_sat, w_result;

    assign w_slot_ok = {1'b0, r_slot} < SLOT_LIMIT;
    assign w_upper   = r_raw > SRC_CENTER_V;

    assign w_span_mag  = w_upper ? SPAN_HI_MAG : SPAN_LO_MAG;
    assign w_span_neg  = w_upper ? SPAN_HI_NEG : SPAN_LO_NEG;
    assign w_span_zero = (w_span_mag == '0);

    assign w_lo  = i_cal[sosf_pkg::LO_LSB  +: VW];
    assign w_mid = i_cal[sosf_pkg::MID_LSB +: VW];
    assign w_hi  = i_cal[sosf_pkg::HI_LSB  +: VW];

    assign w_src_a = w_upper ? SRC_CENTER_V : SRC_MIN_V;
    assign w_out_a = w_upper ? w_mid : w_lo;
    assign w_out_b = w_upper ? w_hi : w_mid;

    assign w_dx     = {1'b0, r_raw} - {1'b0, w_src_a};
    assign w_dy     = {1'b0, w_out_b} - {1'b0, w_out_a};
    assign w_dx_abs = w_dx[VW] ? (~w_dx + 1'b1) : w_dx;
    assign w_dy_abs = w_dy[VW] ? (~w_dy + 1'b1) : w_dy;

    assign w_prod = PW'(r_dx_mag) * PW'(r_dy_mag);

    // magnitude quotient by the fixed span through its reciprocal
    assign w_qprod = (PW + RW)'(r_prod) * (PW + RW)'(r_recip);
    assign w_quo   = r_upper ? PW'(w_qprod >> SHIFT_HI) : PW'(w_qprod >> SHIFT_LO);

    assign w_q_ext = {{(SW-PW){1'b0}}, r_quo};
    assign w_sq    = r_neg ? (~w_q_ext + 1'b1) : w_q_ext;
    assign w_sum   = {{(SW-VW){1'b0}}, r_base} + w_sq;

    assign w_hidx  = r_slot[HOLD_IDX_W-1:0];
    assign w_hold  = r_hold_val[w_hidx];
    assign w_known = r_hold_known[w_hidx];

    // mirror on the unsaturated value, then clamp to the 12-bit range
    assign w_rev_v = {{(SW+1-VW){1'b0}}, r_lo} + {{(SW+1-VW){1'b0}}, r_hi}
                     - {r_v[SW-1], r_v};
    assign w_fin   = r_rev ? w_rev_v : {r_v[SW-1], r_v};

    always_comb begin
        if (w_fin[SW]) begin
            w_sat = '0;
        end else if (|w_fin[SW-1:VW]) begin
            w_sat = sosf_pkg::VAL_MAX;
        end else begin
            w_sat = w_fin[VW-1:0];
        end
    end

    assign w_result = r_scaled ? w_sat : r_direct;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_slot  <= i_slot_index;
            r_valid <= i_source_valid;
            r_raw   <= i_raw_value;
        end
        if (i_cmd.prep) begin
            r_lo        <= w_lo;
            r_mid       <= w_mid;
            r_hi        <= w_hi;
            r_rev       <= i_cal[sosf_pkg::REV_BIT];
            r_fix       <= i_cal[sosf_pkg::FIX_BIT];
            r_fixv      <= i_cal[sosf_pkg::FIXV_LSB +: VW];
            r_dx_mag    <= w_dx_abs[VW-1:0];
            r_dy_mag    <= w_dy_abs[VW-1:0];
            r_neg       <= w_dx[VW] ^ w_dy[VW] ^ w_span_neg;
            r_recip     <= w_upper ? REC_HI_V : REC_LO_V;
            r_upper     <= w_upper;
            r_span_zero <= w_span_zero;
            r_base      <= w_out_a;
            r_endpt     <= w_upper ? w_hi : w_lo;
            r_scaled    <= w_slot_ok && r_valid;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.div_step) begin
            r_quo <= w_quo;
        end
        if (i_cmd.sum) begin
            r_v <= r_span_zero ? {{(SW-VW){1'b0}}, r_endpt} : w_sum;
            if (!w_slot_ok) begin
                r_direct <= '0;
            end else if (r_fix) begin
                r_direct <= r_fixv;
            end else if (w_known) begin
                r_direct <= w_hold;
            end else begin
                r_direct <= r_mid;
            end
        end
        if (i_cmd.load_out) begin
            r_out_slot <= r_slot;
            r_out_val  <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out && r_scaled) begin
            r_hold_val[w_hidx] <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_known <= '0;
        end else if (i_cmd.load_out && r_scaled) begin
            r_hold_known[w_hidx] <= 1'b1;
        end
    end

    assign o_status.direct = !w_slot_ok || !r_valid || w_span_zero;

    assign o_cal_slot    = r_slot;
    assign o_slot_echo   = r_out_slot;
    assign o_servo_value = r_out_val;

endmodule

@@ hdl/servo_output_scale_failsafe.sv @@
// ----------------------------------------------------------------------------
// servo_output_scale_failsafe
// per-slot servo endpoint and centre mapping with failsafe hold
// ----------------------------------------------------------------------------
// i_in carries one transaction per servo update: slot index, a validity flag
// and the raw channel value; o_out returns one transaction per input with
// the slot echoed and the saturated pulse value. i_cfg_we/i_cfg_index/
// i_cfg_data write the eight 50-bit slot calibration words; the user must
// write them only while idle, the block itself does not enforce it.
// a valid value on a slot in range is scaled by a 12x12 multiply, then
// divided by the fixed source span through a reciprocal multiply, in the
// prepare, multiply, divide and sum states. failsafe values, ignored slots
// and zero-width source spans bypass both multiplies (prepare, sum only).
// one transaction is in flight at a time; a finished result sits in the
// output register so the next input is taken while it waits to be drained.
// when o_out is stalled the result holds and the block stops before loading
// the next one. reset restores the calibration defaults and forgets all
// held values, so a failsafe before any good value gives the slot centre.
// ----------------------------------------------------------------------------
`include "servo_output_scale_failsafe_assert.svh"

module servo_output_scale_failsafe #(
    parameter int SLOT_COUNT    = 8,
    parameter int SOURCE_MIN    = 1000,
    parameter int SOURCE_CENTER = 1500,
    parameter int SOURCE_MAX    = 2000
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sosf_in_if.sink                         i_in,
    sosf_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [sosf_pkg::CAL_IDX_W-1:0]  i_cfg_index,
    input  logic [sosf_pkg::CAL_W-1:0]      i_cfg_data
);

    sosf_pkg::t_cmd              w_cmd;
    sosf_pkg::t_status           w_status;
    logic [sosf_pkg::CAL_W-1:0]  w_cal;
    logic [sosf_pkg::SLOT_W-1:0] w_cal_slot;

    sosf_cfg_regs u_cfg_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (i_cfg_we),
        .i_index   (i_cfg_index),
        .i_data    (i_cfg_data),
        .i_rd_slot (w_cal_slot),
        .o_cal     (w_cal)
    );

    sosf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    sosf_datapath #(
        .SLOT_COUNT    (SLOT_COUNT),
        .SOURCE_MIN    (SOURCE_MIN),
        .SOURCE_CENTER (SOURCE_CENTER),
        .SOURCE_MAX    (SOURCE_MAX)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_slot_index   (i_in.slot_index),
        .i_source_valid (i_in.source_valid),
        .i_raw_value    (i_in.raw_value),
        .i_cal          (w_cal),
        .o_cal_slot     (w_cal_slot),
        .o_slot_echo    (o_out.slot_echo),
        .o_servo_value  (o_out.servo_value)
    );

    // an accepted transaction closes the input in the cycle after it
    `SOSF_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "input accepted again straight after a transaction")

    // no new input while the divider is stepping
    `SOSF_ASSERT_IMP(a_no_accept_in_div, i_clk, i_rst_n, w_cmd.div_step, !i_in.ready, "input ready while dividing")

    // the output register is only loaded when it is free or draining
    `SOSF_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_cmd.load_out, !o_out.valid || o_out.ready, "pending result overwritten")

endmodule

@@ test/servo_output_scale_failsafe_test.sv @@
// ----------------------------------------------------------------------------
// servo_output_scale_failsafe_test
// self-checking bench for the per-slot servo mapping with failsafe hold.
// a short directed run exercises the mapping extremes, reverse, fixed and
// held failsafe and flat segments; random phases follow, each with fresh
// calibration words. every result is compared against an in-bench model.
// ----------------------------------------------------------------------------
module servo_output_scale_failsafe_test;

    localparam int VW  = sosf_pkg::VAL_W;
    localparam int SLW = sosf_pkg::SLOT_W;
    localparam int CW  = sosf_pkg::CAL_W;
    localparam int IW  = sosf_pkg::CAL_IDX_W;

    localparam int SLOTS         = 8;
    localparam int SRC_MIN       = 1000;
    localparam int SRC_CENTER    = 1500;
    localparam int SRC_MAX       = 2000;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 121;
    localparam int REPORT_CAP    = 40;

    localparam logic [CW-1:0] CAL_ALL_ONES = '1;
    localparam logic [CW-1:0] CAL_ZERO     = '0;

    typedef struct packed {
        logic [SLW-1:0] slot;
        logic [VW-1:0]  pulse;
    } t_pulse;

    // model of the slot calibration and hold state plus the outstanding pulses
    class pulse_checker;
        logic [CW-1:0] cal [SLOTS];
        logic [VW-1:0] held [SLOTS];
        bit            held_known [SLOTS];
        t_pulse        due_pulses [$];
        int errors, checked, mapped, failsafe, fixed_out, saturated, reversed;

        function new();
            for (int s = 0; s < SLOTS; s++) begin
                cal[s]        = sosf_pkg::CAL_RESET;
                held[s]       = '0;
                held_known[s] = 1'b0;
            end
        endfunction

        function void set_cal(logic [IW-1:0] idx, logic [CW-1:0] word);
            cal[idx] = word;
        endfunction

        function logic [VW-1:0] predict_pulse(logic [SLW-1:0] slot,
                                              logic ok, logic [VW-1:0] raw_in);
            int lo, mid, hi, raw, v, span;
            logic [CW-1:0] w;
            w   = cal[slot];
            lo  = int'(w[sosf_pkg::LO_LSB +: VW]);
            mid = int'(w[sosf_pkg::MID_LSB +: VW]);
            hi  = int'(w[sosf_pkg::HI_LSB +: VW]);
            raw = int'(raw_in);
            if (!ok) begin
                failsafe++;
                if (w[sosf_pkg::FIX_BIT]) begin
                    fixed_out++;
                    return w[sosf_pkg::FIXV_LSB +: VW];
                end
                return held_known[slot] ? held[slot] : VW'(mid);
            end
            mapped++;
            if (raw <= SRC_CENTER) begin
                span = SRC_CENTER - SRC_MIN;
                v = (span == 0) ? lo : lo + ((raw - SRC_MIN) * (mid - lo)) / span;
            end else begin
                span = SRC_MAX - SRC_CENTER;
                v = (span == 0) ? hi : mid + ((raw - SRC_CENTER) * (hi - mid)) / span;
            end
            if (w[sosf_pkg::REV_BIT]) begin
                reversed++;
                v = lo + hi - v;
            end
            if (v < 0 || v > 4095) saturated++;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            held[slot]       = VW'(v);
            held_known[slot] = 1'b1;
            return VW'(v);
        endfunction

        function void note_input(logic [SLW-1:0] slot, logic ok, logic [VW-1:0] raw);
            t_pulse p;
            p.slot  = slot;
            p.pulse = predict_pulse(slot, ok, raw);
            due_pulses.push_back(p);
        endfunction

        function int pending();
            return due_pulses.size();
        endfunction

        task report(string what);
            if (errors < REPORT_CAP) $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(logic [SLW-1:0] slot, logic [VW-1:0] pulse);
            t_pulse want;
            if (due_pulses.size() == 0) begin
                report($sformatf("slot %0d pulse %0d with nothing outstanding", slot, pulse));
                return;
            end
            want = due_pulses.pop_front();
            checked++;
            if (slot !== want.slot)
                report($sformatf("slot echo %0d, wanted %0d", slot, want.slot));
            if (pulse !== want.pulse)
                report($sformatf("slot %0d pulse %0d, wanted %0d", want.slot, pulse,
                                 want.pulse));
        endtask
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          cfg_we;
    logic [IW-1:0] cfg_index;
    logic [CW-1:0] cfg_data;

    sosf_in_if  in_ch ();
    sosf_out_if out_ch ();

    servo_output_scale_failsafe #(
        .SLOT_COUNT    (SLOTS),
        .SOURCE_MIN    (SRC_MIN),
        .SOURCE_CENTER (SRC_CENTER),
        .SOURCE_MAX    (SRC_MAX)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pulse_checker sb = new();

    bit in_idling;
    bit out_idling;
    int ready_hold;
    int idle_cycles;
    int settings;

    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        in_ch.valid         = 1'b0;
        in_ch.slot_index    = '0;
        in_ch.source_valid  = 1'b0;
        in_ch.raw_value     = '0;
        out_ch.ready        = 1'b1;
    end

    always #2 i_clk = ~i_clk;

    // sink side stalls in short bursts
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            out_ch.ready = 1'b0;
            ready_hold--;
        end else if (out_idling && $urandom_range(0, 4) == 0) begin
            out_ch.ready = 1'b0;
            ready_hold   = $urandom_range(0, 2);
        end else begin
            out_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.slot_echo, out_ch.servo_value);
            if (in_ch.valid && in_ch.ready)
                sb.note_input(in_ch.slot_index, in_ch.source_valid, in_ch.raw_value);
            if (cfg_we)
                sb.set_cal(cfg_index, cfg_data);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(int slot, bit ok, int raw);
        int gap;
        gap = 0;
        if (in_idling && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid        = 1'b1;
        in_ch.slot_index   = SLW'(slot);
        in_ch.source_valid = ok;
        in_ch.raw_value    = VW'(raw);
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_random_item();
        int raw;
        case ($urandom_range(0, 9))
            0, 1: raw = $urandom_range(0, 4095);
            2: begin
                case ($urandom_range(0, 7))
                    0: raw = 0;
                    1: raw = 4095;
                    2: raw = SRC_MIN - 1;
                    3: raw = SRC_MIN;
                    4: raw = SRC_CENTER;
                    5: raw = SRC_CENTER + 1;
                    6: raw = SRC_MAX;
                    default: raw = SRC_MAX + 1;
                endcase
            end
            default: raw = $urandom_range(SRC_MIN, SRC_MAX);
        endcase
        send_item($urandom_range(0, SLOTS - 1), $urandom_range(0, 4) != 0, raw);
    endtask

    task automatic stop_input();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // only called while the block is idle
    task automatic write_cal(int idx, logic [CW-1:0] word);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = IW'(idx);
        cfg_data  = word;
        @(negedge i_clk);
        cfg_we    = 1'b0;
    endtask

    task automatic settle();
        stop_input();
        wait_drained();
        repeat (8) @(posedge i_clk);
    endtask

    function automatic int pick_point(int base);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 4095;
            2: return $urandom_range(0, 4095);
            default: return base - 200 + $urandom_range(0, 400);
        endcase
    endfunction

    function automatic logic [CW-1:0] random_cal();
        logic [VW-1:0] lo, mid, hi, fixv;
        logic          rev, fix;
        case ($urandom_range(0, 9))
            0: return CAL_ZERO;
            1: return CAL_ALL_ONES;
            2: return sosf_pkg::CAL_RESET;
            default: ;
        endcase
        lo   = VW'(pick_point(SRC_MIN));
        mid  = VW'(pick_point(SRC_CENTER));
        hi   = VW'(pick_point(SRC_MAX));
        // flat segments now and then
        if ($urandom_range(0, 7) == 0) mid = lo;
        if ($urandom_range(0, 7) == 0) hi = mid;
        rev  = 1'($urandom_range(0, 1));
        fix  = ($urandom_range(0, 3) == 0);
        fixv = VW'($urandom_range(0, 4095));
        return {fixv, fix, rev, hi, mid, lo};
    endfunction

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        settings = 1;

        // reset calibration: failsafe centre and held output, segment edges
        send_item(0, 1'b0, 4095);
        send_item(0, 1'b1, 0);
        send_item(0, 1'b0, 0);
        send_item(1, 1'b1, 4095);
        send_item(2, 1'b1, SRC_MIN);
        send_item(2, 1'b1, SRC_CENTER);
        send_item(2, 1'b1, SRC_CENTER + 1);
        send_item(2, 1'b1, SRC_MAX);
        send_item(3, 1'b1, SRC_CENTER - 1);
        send_item(7, 1'b0, 0);
        send_item(7, 1'b1, 2047);
        send_item(7, 1'b0, 2048);
        settle();

        // reverse, fixed failsafe, flat lower segment, falling line, extremes
        write_cal(0, {12'd1500, 1'b0, 1'b1, 12'd2000, 12'd1500, 12'd1000});
        write_cal(1, {12'd4095, 1'b1, 1'b0, 12'd2000, 12'd1500, 12'd1000});
        write_cal(2, {12'd0, 1'b0, 1'b0, 12'd1800, 12'd1200, 12'd1200});
        write_cal(3, {12'd0, 1'b0, 1'b0, 12'd0, 12'd2048, 12'd4095});
        write_cal(4, CAL_ALL_ONES);
        write_cal(5, CAL_ZERO);
        write_cal(6, {12'd0, 1'b0, 1'b1, 12'd4095, 12'd0, 12'd0});
        write_cal(7, sosf_pkg::CAL_RESET);
        settings++;
        send_item(0, 1'b1, 1200);
        send_item(1, 1'b1, 1800);
        send_item(1, 1'b0, 0);
        send_item(2, 1'b1, 1100);
        send_item(2, 1'b1, 1900);
        send_item(3, 1'b1, SRC_MIN + 1);
        send_item(3, 1'b1, 4095);
        send_item(4, 1'b1, 0);
        send_item(4, 1'b0, 4095);
        send_item(5, 1'b1, 3000);
        send_item(5, 1'b0, 0);
        send_item(6, 1'b1, 4095);
        send_item(6, 1'b1, 0);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            for (int s = 0; s < SLOTS; s++) write_cal(s, random_cal());
            settings++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) begin
                    in_idling  = (p != RANDOM_PHASES - 1) && $urandom_range(0, 3) != 0;
                    out_idling = (p != RANDOM_PHASES - 1) && $urandom_range(0, 3) != 0;
                end
                // hold the sender off until everything outstanding is back
                if (p == 2 && n == 60) begin
                    stop_input();
                    wait_drained();
                end
                send_random_item();
            end
            settle();
        end

        repeat (40) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d pulses never arrived", sb.pending()));

        $display("checked %0d transactions across %0d calibration settings",
                 sb.checked, settings);
        $display("%0d mapped (%0d reversed, %0d saturated), %0d failsafe (%0d fixed)",
                 sb.mapped, sb.reversed, sb.saturated, sb.failsafe, sb.fixed_out);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ servo_output_scale_failsafe.f @@
+incdir+hdl
hdl/sosf_pkg.sv
hdl/sosf_in_if.sv
hdl/sosf_out_if.sv
hdl/sosf_cfg_regs.sv
hdl/sosf_ctrl.sv
hdl/sosf_datapath.sv
hdl/servo_output_scale_failsafe.sv
test/servo_output_scale_failsafe_test.sv
